// ===== hdl/pcd_pkg.sv =====
// Shared types, constants and the constant-divide helpers for the proximity
// calibrate-and-detect block. No dependencies.
package pcd_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned CALIB_W    = 3;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned TOTAL_W    = 19;
    localparam int unsigned HIT_SUM_W  = 20;

    localparam logic [CALIB_W-1:0]  CALIB_SAMPLES  = 3'd5;
    localparam logic [COUNT_W-1:0]  HITS_NEEDED    = 4'd10;
    localparam logic [COUNT_W-1:0]  MISS_LIMIT     = 4'd9;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST  = 16'd25;

    // Reciprocal of 5 scaled by 2^21, rounded up; exact for all 19-bit inputs.
    localparam logic [18:0] DIV5_MULT  = 19'd419431;
    localparam int unsigned DIV5_SHIFT = 21;

    typedef enum logic {
        KIND_CALIB  = 1'b0,
        KIND_DETECT = 1'b1
    } t_event_kind;

    typedef struct packed {
        logic                valid;
        t_event_kind         kind;
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] calib_min;
        logic [SAMPLE_W-1:0] calib_max;
    } t_result;

    // Divide a 19-bit value by five; keep the low 16 bits of the quotient.
    function automatic logic [SAMPLE_W-1:0] div5(input logic [TOTAL_W-1:0] x);
        logic [37:0] p;
        p = 38'(x) * 38'(DIV5_MULT);
        return p[DIV5_SHIFT +: SAMPLE_W];
    endfunction

    // Divide a 20-bit value by ten as a halving followed by a divide by five.
    function automatic logic [SAMPLE_W-1:0] div10(input logic [HIT_SUM_W-1:0] x);
        return div5(x[HIT_SUM_W-1:1]);
    endfunction

endpackage

// ===== hdl/pcd_in_reg.sv =====
// Input register of the proximity calibrate-and-detect block.
// Captures one sample transfer and holds it until the engine advances.
// Depends on pcd_pkg.
module pcd_in_reg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [pcd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                         i_adv,
    output logic                         o_valid,
    output logic [pcd_pkg::SAMPLE_W-1:0] o_sample
);

    logic                         r_valid;
    logic                         n_valid;
    logic [pcd_pkg::SAMPLE_W-1:0] r_sample;

    assign s_axis_tready = !r_valid || i_adv;

    always_comb begin
        n_valid = r_valid;
        if (s_axis_tvalid && s_axis_tready) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_sample <= i_sample;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

// ===== hdl/pcd_engine.sv =====
// Calibration and detection state with the single-pass result logic.
// Holds the threshold register and all round counters. Depends on pcd_pkg.
module pcd_engine #(
    parameter logic [pcd_pkg::COUNT_W-1:0] MISS_LIMIT = pcd_pkg::MISS_LIMIT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [pcd_pkg::SAMPLE_W-1:0] i_cfg_wr_data,
    input  logic                         i_en,
    input  logic [pcd_pkg::SAMPLE_W-1:0] i_sample,
    output pcd_pkg::t_result             o_result
);

    logic [pcd_pkg::SAMPLE_W-1:0]  r_threshold;
    logic [pcd_pkg::CALIB_W-1:0]   r_calib_idx, n_calib_idx;
    logic [pcd_pkg::SAMPLE_W-1:0]  r_run_min, n_run_min;
    logic [pcd_pkg::SAMPLE_W-1:0]  r_run_max, n_run_max;
    logic [pcd_pkg::TOTAL_W-1:0]   r_run_total, n_run_total;
    logic [pcd_pkg::SAMPLE_W-1:0]  r_offset, n_offset;
    logic [pcd_pkg::COUNT_W-1:0]   r_miss_cnt, n_miss_cnt;
    logic [pcd_pkg::COUNT_W-1:0]   r_hit_cnt, n_hit_cnt;
    logic [pcd_pkg::HIT_SUM_W-1:0] r_hit_sum, n_hit_sum;

    logic                          calib_phase;
    logic                          is_hit;
    logic [pcd_pkg::SAMPLE_W:0]    hit_limit;
    logic [pcd_pkg::COUNT_W-1:0]   hit_cnt_inc;
    logic [pcd_pkg::COUNT_W-1:0]   miss_cnt_inc;
    logic [pcd_pkg::HIT_SUM_W-1:0] hit_sum_inc;
    pcd_pkg::t_result              result;

    assign calib_phase  = (r_calib_idx != pcd_pkg::CALIB_SAMPLES);
    // Offset plus threshold at 17 bits never wraps.
    assign hit_limit    = {1'b0, r_offset} + {1'b0, r_threshold};
    assign is_hit       = ({1'b0, i_sample} > hit_limit);
    assign hit_cnt_inc  = r_hit_cnt + 1'b1;
    assign miss_cnt_inc = r_miss_cnt + 1'b1;
    assign hit_sum_inc  = r_hit_sum + pcd_pkg::HIT_SUM_W'(i_sample);

    always_comb begin
        n_calib_idx = r_calib_idx;
        n_run_min   = r_run_min;
        n_run_max   = r_run_max;
        n_run_total = r_run_total;
        n_offset    = r_offset;
        n_miss_cnt  = r_miss_cnt;
        n_hit_cnt   = r_hit_cnt;
        n_hit_sum   = r_hit_sum;
        result      = '{valid: 1'b0, kind: pcd_pkg::KIND_CALIB,
                        level: '0, calib_min: '0, calib_max: '0};
        if (i_en) begin
            if (calib_phase) begin
                // First calibration sample loads the running values directly.
                if (r_calib_idx == '0) begin
                    n_run_min   = i_sample;
                    n_run_max   = i_sample;
                    n_run_total = pcd_pkg::TOTAL_W'(i_sample);
                end else begin
                    if (i_sample < r_run_min) begin
                        n_run_min = i_sample;
                    end
                    if (i_sample > r_run_max) begin
                        n_run_max = i_sample;
                    end
                    n_run_total = r_run_total + pcd_pkg::TOTAL_W'(i_sample);
                end
                n_calib_idx = r_calib_idx + 1'b1;
                if (n_calib_idx == pcd_pkg::CALIB_SAMPLES) begin
                    n_offset           = pcd_pkg::div5(n_run_total);
                    result.valid       = 1'b1;
                    result.kind        = pcd_pkg::KIND_CALIB;
                    result.level       = n_offset;
                    result.calib_min   = n_run_min;
                    result.calib_max   = n_run_max;
                end
            end else if (is_hit) begin
                n_hit_sum = hit_sum_inc;
                n_hit_cnt = hit_cnt_inc;
                if (hit_cnt_inc >= pcd_pkg::HITS_NEEDED) begin
                    result.valid = 1'b1;
                    result.kind  = pcd_pkg::KIND_DETECT;
                    result.level = pcd_pkg::div10(hit_sum_inc);
                    n_miss_cnt   = '0;
                    n_hit_cnt    = '0;
                    n_hit_sum    = '0;
                end
            end else begin
                n_miss_cnt = miss_cnt_inc;
                if (miss_cnt_inc >= MISS_LIMIT) begin
                    n_miss_cnt = '0;
                    n_hit_cnt  = '0;
                    n_hit_sum  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= pcd_pkg::THRESHOLD_RST;
            r_calib_idx <= '0;
            r_run_min   <= '0;
            r_run_max   <= '0;
            r_run_total <= '0;
            r_offset    <= '0;
            r_miss_cnt  <= '0;
            r_hit_cnt   <= '0;
            r_hit_sum   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_threshold <= i_cfg_wr_data;
            end
            r_calib_idx <= n_calib_idx;
            r_run_min   <= n_run_min;
            r_run_max   <= n_run_max;
            r_run_total <= n_run_total;
            r_offset    <= n_offset;
            r_miss_cnt  <= n_miss_cnt;
            r_hit_cnt   <= n_hit_cnt;
            r_hit_sum   <= n_hit_sum;
        end
    end

    assign o_result = result;

    a_calib_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_calib_idx <= pcd_pkg::CALIB_SAMPLES)
        else $error("calibration index past its limit");

    a_hit_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit_cnt < pcd_pkg::HITS_NEEDED)
        else $error("hit count reached the detect level without clearing");

    a_miss_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_miss_cnt < MISS_LIMIT)
        else $error("miss count reached its limit without clearing");

    a_detect_after_calib: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (result.valid && result.kind == pcd_pkg::KIND_DETECT) |-> !calib_phase)
        else $error("detection result before calibration finished");

    a_calib_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (result.valid && result.kind == pcd_pkg::KIND_CALIB)
            |=> (r_calib_idx == pcd_pkg::CALIB_SAMPLES && r_hit_cnt == '0))
        else $error("calibration result without ending calibration");

endmodule

// ===== hdl/proximity_calibrate_and_detect.sv =====
// Top level of the proximity calibrate-and-detect block.
// Instantiates pcd_in_reg and pcd_engine and holds the result register.
// Depends on pcd_pkg.
//
// Usage: feed one 16-bit sample per slave transfer. The first five samples
// calibrate the block; the fifth produces one result transfer with tuser 0
// (calibration finished) carrying the offset (sum of the five divided by
// five), the minimum and the maximum. After that, detection rounds run: a
// sample strictly above offset plus the threshold is a hit, anything else a
// miss. The tenth hit of a round produces one result with tuser 1 carrying
// the hit average (sum of the ten hits divided by ten) and zeros for the
// minimum and maximum; MISS_LIMIT misses (nine by default) end a round
// silently. Either end clears the round counters. Throughput is one sample
// per clock while no finished result waits on a low m_axis_tready: a sample
// is held in the input register while the compare, add and reciprocal-
// multiply divide settle combinationally, and the result lands in the output
// register, from which it is presented on the master side. The block only
// stalls intake while a finished result waits on a low m_axis_tready. Write
// the threshold (reset value 25) through i_cfg_wr_en / i_cfg_wr_data while
// no sample is in flight; it applies from the next sample and clears no
// counter.
module proximity_calibrate_and_detect #(
    parameter logic [pcd_pkg::COUNT_W-1:0] MISS_LIMIT = pcd_pkg::MISS_LIMIT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Threshold register write
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // Sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] level, [31:16] calib_min,
                                        // [47:32] calib_max
    output logic        m_axis_tuser    // [0] event_kind
);

    logic                         in_valid;
    logic [pcd_pkg::SAMPLE_W-1:0] in_sample;
    logic                         adv;
    pcd_pkg::t_result             result;

    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [47:0]                  r_out_data;
    logic                         r_out_kind;

    // Advance the held sample whenever the result register is free or draining.
    assign adv = in_valid && (!r_out_valid || m_axis_tready);

    pcd_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sample      (s_axis_tdata),
        .i_adv         (adv),
        .o_valid       (in_valid),
        .o_sample      (in_sample)
    );

    pcd_engine #(
        .MISS_LIMIT    (MISS_LIMIT)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_en          (adv),
        .i_sample      (in_sample),
        .o_result      (result)
    );

    // Result register: load on advance, drop once the transfer completes.
    always_comb begin
        n_out_valid = r_out_valid;
        if (adv) begin
            n_out_valid = result.valid;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && result.valid) begin
            r_out_data <= {result.calib_max, result.calib_min, result.level};
            r_out_kind <= result.kind;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !adv)
        else $error("pending result overwritten");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> $stable(r_out_data))
        else $error("result payload changed under stall");

    a_intake_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid) |-> s_axis_tready)
        else $error("intake stalled with an empty result register");

endmodule

// ===== bench/pcd_event_checker.sv =====
// Watches the sample, threshold and result channels of the proximity block,
// predicts each calibration and detection event and compares it on transfer.
// Depends on pcd_pkg.
module pcd_event_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // [15:0] level, [31:16] calib_min,
                                        // [47:32] calib_max
    input  logic        m_axis_tuser,   // [0] event_kind
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        pcd_pkg::t_event_kind         kind;
        logic [pcd_pkg::SAMPLE_W-1:0] level;
        logic [pcd_pkg::SAMPLE_W-1:0] calib_min;
        logic [pcd_pkg::SAMPLE_W-1:0] calib_max;
    } t_pcd_event;

    t_pcd_event                    expected_events [$];
    int                            mismatch_count;

    logic [pcd_pkg::SAMPLE_W-1:0]  threshold;
    logic [pcd_pkg::CALIB_W-1:0]   cal_count;
    logic [pcd_pkg::SAMPLE_W-1:0]  cal_lo;
    logic [pcd_pkg::SAMPLE_W-1:0]  cal_hi;
    logic [pcd_pkg::TOTAL_W-1:0]   cal_total;
    logic [pcd_pkg::SAMPLE_W-1:0]  base_level;
    logic [pcd_pkg::COUNT_W-1:0]   misses;
    logic [pcd_pkg::COUNT_W-1:0]   hits;
    logic [pcd_pkg::HIT_SUM_W-1:0] hit_total;

    task automatic clear_round_counters();
        misses    = '0;
        hits      = '0;
        hit_total = '0;
    endtask

    task automatic predict_event(input logic [pcd_pkg::SAMPLE_W-1:0] s);
        logic [pcd_pkg::SAMPLE_W:0] hit_bound;
        if (cal_count < pcd_pkg::CALIB_SAMPLES) begin
            if (cal_count == '0) begin
                cal_lo    = s;
                cal_hi    = s;
                cal_total = pcd_pkg::TOTAL_W'(s);
            end else begin
                if (s < cal_lo) cal_lo = s;
                if (s > cal_hi) cal_hi = s;
                cal_total = cal_total + pcd_pkg::TOTAL_W'(s);
            end
            cal_count = cal_count + 1'b1;
            if (cal_count == pcd_pkg::CALIB_SAMPLES) begin
                base_level = pcd_pkg::SAMPLE_W'(cal_total
                             / pcd_pkg::TOTAL_W'(pcd_pkg::CALIB_SAMPLES));
                expected_events.push_back('{pcd_pkg::KIND_CALIB, base_level,
                                            cal_lo, cal_hi});
            end
        end else begin
            // 17-bit bound: never wraps, so a large threshold blocks every hit
            hit_bound = {1'b0, base_level} + {1'b0, threshold};
            if ({1'b0, s} > hit_bound) begin
                hit_total = hit_total + pcd_pkg::HIT_SUM_W'(s);
                hits      = hits + 1'b1;
                if (hits >= pcd_pkg::HITS_NEEDED) begin
                    expected_events.push_back('{pcd_pkg::KIND_DETECT,
                        pcd_pkg::SAMPLE_W'(hit_total
                            / pcd_pkg::HIT_SUM_W'(pcd_pkg::HITS_NEEDED)), '0, '0});
                    clear_round_counters();
                end
            end else begin
                misses = misses + 1'b1;
                if (misses >= pcd_pkg::MISS_LIMIT) clear_round_counters();
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pcd_event want;
        if (!i_rst_n) begin
            threshold  = pcd_pkg::THRESHOLD_RST;
            cal_count  = '0;
            cal_lo     = '0;
            cal_hi     = '0;
            cal_total  = '0;
            base_level = '0;
            clear_round_counters();
            expected_events.delete();
            mismatch_count = 0;
        end else begin
            // Compare the result first: a sample at this edge cannot answer now
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h / %0d",
                             $time, m_axis_tdata, m_axis_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", want.kind, m_axis_tuser);
                    check_field("level", want.level, m_axis_tdata[15:0]);
                    check_field("calib_min", want.calib_min, m_axis_tdata[31:16]);
                    check_field("calib_max", want.calib_max, m_axis_tdata[47:32]);
                end
            end
            if (i_cfg_wr_en) threshold = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) predict_event(s_axis_tdata);
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_events.size();
    end

endmodule

// ===== bench/proximity_calibrate_and_detect_test.sv =====
// Top of the proximity calibrate-and-detect bench: clock, reset, sample and
// threshold stimulus, result back-pressure and the verdict.
// Depends on pcd_pkg, the block and pcd_event_checker.
module proximity_calibrate_and_detect_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASES      = 11;
    localparam int unsigned PHASE_ITEMS = 103;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_wr_en    = 1'b0;
    logic [15:0] i_cfg_wr_data  = '0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata   = '0;   // [15:0] sample
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [47:0] m_axis_tdata;          // [15:0] level, [31:16] calib_min,
                                        // [47:32] calib_max
    logic        m_axis_tuser;          // [0] event_kind

    int          mismatches;
    int          pending;
    int unsigned cycle_count;
    bit          no_idle = 1'b0;

    // Calibration set: the minimum comes from the second sample, the maximum is
    // the field's top value.
    logic [15:0] calib_set [5] = '{16'd50000, 16'd7, 16'd65535, 16'd300, 16'd12};
    int unsigned base_est;

    proximity_calibrate_and_detect uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pcd_event_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Abort a hung run once the cycle budget is spent.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** proximity_calibrate_and_detect: FAILED **");
        $finish;
    end

    // Result side: drop tready for a random stall before accepting each transfer;
    // with no_idle set, tready stays high across back-to-back transfers.
    initial begin
        int unsigned stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Offer one sample after a random gap and hold it until the transfer.
    task automatic send_sample(input logic [15:0] value);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Drop tvalid, drain every predicted result, then let the last silent
    // sample clear the two-stage pipe before touching the register.
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly hits or misses around the detection bound so that rounds run to
    // ten hits or nine misses; a tenth of the samples is raw noise.
    function automatic logic [15:0] draw_sample(input int unsigned bound,
                                                input int unsigned hit_pct);
        if ($urandom_range(0, 99) < 10) return 16'($urandom);
        if (bound < 65535 && $urandom_range(1, 100) <= hit_pct)
            return 16'($urandom_range(bound + 1, 65535));
        return 16'($urandom_range(0, (bound > 65535) ? 65535 : bound));
    endfunction

    initial begin
        int unsigned thr;
        int unsigned hit_pct;
        base_est = 0;
        foreach (calib_set[k]) base_est += calib_set[k];
        base_est = base_est / 5;

        // Hold reset low at the start, then release it for good.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Calibrate under the reset threshold.
        foreach (calib_set[k]) send_sample(calib_set[k]);

        // Full round of hits: lowest hitting sample and the top value.
        send_sample(16'(base_est + 26));
        repeat (9) send_sample(16'hFFFF);

        // One hit, then nine misses: the bound itself is a miss, and the
        // round ends silently with the hit discarded.
        send_sample(16'(base_est + 26));
        send_sample(16'(base_est + 25));
        send_sample(16'd0);
        send_sample(16'd1);
        send_sample(16'd100);
        send_sample(16'(base_est + 25));
        send_sample(16'd5000);
        send_sample(16'd0);
        send_sample(16'(base_est - 170));
        send_sample(16'(base_est + 25));

        // Random phases, each under its own threshold: zero, full scale,
        // the last bound that lets the top value hit, the first one that
        // blocks every hit, the reset value, then random settings.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       thr = 0;
                1:       thr = 65535;
                2:       thr = 65534 - base_est;
                3:       thr = 65535 - base_est;
                4:       thr = 25;
                default: thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 3000);
            endcase
            wait_for_idle();
            write_threshold(16'(thr));
            no_idle = ($urandom_range(0, 3) == 0);
            hit_pct = $urandom_range(50, 90);
            repeat (PHASE_ITEMS) send_sample(draw_sample(base_est + thr, hit_pct));
        end

        // Drain, then allow the pipe latency before the verdict.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("** proximity_calibrate_and_detect: PASSED **");
        end else begin
            $display("** proximity_calibrate_and_detect: FAILED **");
        end
        $finish;
    end

endmodule
